### sv/dd_pkg.sv
// Shared types, constants and calendar tables for the date difference block.
package dd_pkg;

    localparam int YEAR_BITS_DEF = 14;
    localparam int OUT_W         = 23;
    localparam int MUL_B_W       = 13;
    localparam int OFF_W         = 9;
    localparam int RECIP_SHIFT   = 19;

    localparam logic [MUL_B_W-1:0] K_RECIP_100 = 13'd5243;
    localparam logic [MUL_B_W-1:0] K_HUNDRED   = 13'd100;
    localparam logic [MUL_B_W-1:0] K_YEAR_DAYS = 13'd365;
    localparam logic [MUL_B_W-1:0] K_ONE       = 13'd1;

    localparam logic [OUT_W-2:0] OUT_MAX_MAG = 22'd4194303;

    typedef struct packed {
        logic en;
        logic use_acc;
        logic sub;
    } mac_ctl_t;

    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [OFF_W-1:0] days_before(input logic [3:0] m);
        logic [OFF_W-1:0] n;
        case (m)
            4'd1:    n = 9'd0;
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage

### sv/date_difference_days.sv
// Signed day count between two Gregorian dates, top level with sequencer.
// done rises once the sequencer has run both dates, then DIFF, ABS and OUT, after taking the start beat.
// A new start beat is taken only in idle, not while busy; start may be taken in the cycle done is high.
// One shared multiply-accumulate: seven passes per date, two for the magnitude, one output step.
// done is a single-cycle strobe; the receiver cannot stall it.
// rst_n clears the sequencer and the strobe asynchronously; data registers are not reset.
module date_difference_days #(
    parameter int YEAR_BITS = dd_pkg::YEAR_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [4:0]                        first_day,
    input  logic [3:0]                        first_month,
    input  logic [YEAR_BITS-1:0]              first_year,
    input  logic [4:0]                        second_day,
    input  logic [3:0]                        second_month,
    input  logic [YEAR_BITS-1:0]              second_year,
    input  logic                              count_end_day,
    output logic                              done,
    output logic signed [dd_pkg::OUT_W-1:0]   day_difference
);
    import dd_pkg::*;

    localparam int ACC_W = YEAR_BITS + 15;
    localparam int XW    = YEAR_BITS + 1;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_QUOT   = 11'b000_0000_0010,
        S_REM    = 11'b000_0000_0100,
        S_YEARS  = 11'b000_0000_1000,
        S_ADD4   = 11'b000_0001_0000,
        S_SUB100 = 11'b000_0010_0000,
        S_ADD400 = 11'b000_0100_0000,
        S_ADDOFF = 11'b000_1000_0000,
        S_DIFF   = 11'b001_0000_0000,
        S_ABS    = 11'b010_0000_0000,
        S_OUT    = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   side_reg, side_next;
    logic   done_reg, done_next;

    logic [4:0]           fd_reg, sd_reg;
    logic [3:0]           fm_reg, sm_reg;
    logic [YEAR_BITS-1:0] fy_reg, sy_reg;
    logic                 end_reg;
    logic [YEAR_BITS-1:0] q_reg;
    logic [YEAR_BITS-1:0] c100_reg;
    logic [OFF_W-1:0]     off_reg;
    logic signed [ACC_W-1:0] sa_reg;
    logic                 before_reg;
    logic signed [OUT_W-1:0] diff_reg;

    logic [4:0]           cur_d;
    logic [3:0]           cur_m;
    logic [YEAR_BITS-1:0] cur_y;
    logic [XW-1:0]        x;
    logic [XW-1:0]        y_p3;
    logic [XW-1:0]        c100_p3;
    logic [YEAR_BITS-1:0] q_raw;
    logic [YEAR_BITS-1:0] cal_c100;
    logic [OFF_W-1:0]     cal_off;
    logic [OUT_W-2:0]     sat_mag;

    mac_ctl_t                mac_ctl;
    logic signed [ACC_W-1:0] mac_a;
    logic [MUL_B_W-1:0]      mac_b;
    logic signed [ACC_W-1:0] mac_add;
    logic signed [ACC_W-1:0] acc;

    assign cur_d   = side_reg ? sd_reg : fd_reg;
    assign cur_m   = side_reg ? sm_reg : fm_reg;
    assign cur_y   = side_reg ? sy_reg : fy_reg;
    assign x       = {1'b0, cur_y} + XW'(99);
    assign y_p3    = {1'b0, cur_y} + XW'(3);
    assign c100_p3 = {1'b0, c100_reg} + XW'(3);
    assign q_raw   = YEAR_BITS'(acc[ACC_W-1:RECIP_SHIFT]);
    assign sat_mag = (acc > $signed(ACC_W'(OUT_MAX_MAG))) ? OUT_MAX_MAG : acc[OUT_W-2:0];

    dd_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .clk    (clk),
        .ctl    (mac_ctl),
        .a      (mac_a),
        .b      (mac_b),
        .addend (mac_add),
        .acc    (acc)
    );

    dd_cal #(
        .YEAR_BITS (YEAR_BITS),
        .ACC_W     (ACC_W)
    ) u_cal (
        .year      (cur_y),
        .month_raw (cur_m),
        .day_raw   (cur_d),
        .rem       (acc),
        .q         (q_reg),
        .c100      (cal_c100),
        .offset    (cal_off)
    );

    always_comb
    begin
        state_next = state_reg;
        side_next  = side_reg;
        done_next  = 1'b0;
        mac_ctl    = '0;
        mac_a      = '0;
        mac_b      = K_ONE;
        mac_add    = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    side_next  = 1'b0;
                    state_next = S_QUOT;
                end
            end
            S_QUOT:
            begin
                mac_ctl.en = 1'b1;
                mac_a      = $signed(ACC_W'(x));
                mac_b      = K_RECIP_100;
                state_next = S_REM;
            end
            S_REM:
            begin
                mac_ctl.en  = 1'b1;
                mac_ctl.sub = 1'b1;
                mac_a       = $signed(ACC_W'(q_raw));
                mac_b       = K_HUNDRED;
                mac_add     = $signed(ACC_W'(x));
                state_next  = S_YEARS;
            end
            S_YEARS:
            begin
                mac_ctl.en = 1'b1;
                mac_a      = $signed(ACC_W'(cur_y));
                mac_b      = K_YEAR_DAYS;
                state_next = S_ADD4;
            end
            S_ADD4:
            begin
                mac_ctl.en      = 1'b1;
                mac_ctl.use_acc = 1'b1;
                mac_a           = $signed(ACC_W'(y_p3[XW-1:2]));
                state_next      = S_SUB100;
            end
            S_SUB100:
            begin
                mac_ctl.en      = 1'b1;
                mac_ctl.use_acc = 1'b1;
                mac_ctl.sub     = 1'b1;
                mac_a           = $signed(ACC_W'(c100_reg));
                state_next      = S_ADD400;
            end
            S_ADD400:
            begin
                mac_ctl.en      = 1'b1;
                mac_ctl.use_acc = 1'b1;
                mac_a           = $signed(ACC_W'(c100_p3[XW-1:2]));
                state_next      = S_ADDOFF;
            end
            S_ADDOFF:
            begin
                mac_ctl.en      = 1'b1;
                mac_ctl.use_acc = 1'b1;
                mac_a           = $signed(ACC_W'(off_reg));
                if (side_reg)
                begin
                    state_next = S_DIFF;
                end
                else
                begin
                    side_next  = 1'b1;
                    state_next = S_QUOT;
                end
            end
            S_DIFF:
            begin
                mac_ctl.en  = 1'b1;
                mac_ctl.sub = 1'b1;
                mac_a       = acc;
                mac_add     = sa_reg;
                state_next  = S_ABS;
            end
            S_ABS:
            begin
                mac_ctl.en  = 1'b1;
                mac_ctl.sub = acc[ACC_W-1];
                mac_a       = acc;
                mac_add     = $signed(ACC_W'(end_reg));
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            side_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            side_reg  <= side_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && start)
        begin
            fd_reg  <= first_day;
            fm_reg  <= first_month;
            fy_reg  <= first_year;
            sd_reg  <= second_day;
            sm_reg  <= second_month;
            sy_reg  <= second_year;
            end_reg <= count_end_day;
        end
        if (state_reg == S_REM)
        begin
            q_reg <= q_raw;
        end
        if (state_reg == S_YEARS)
        begin
            c100_reg <= cal_c100;
            off_reg  <= cal_off;
        end
        if ((state_reg == S_QUOT) && side_reg)
        begin
            sa_reg <= acc;
        end
        if (state_reg == S_ABS)
        begin
            before_reg <= acc[ACC_W-1];
        end
        if (state_reg == S_OUT)
        begin
            diff_reg <= before_reg ? $signed({1'b0, sat_mag}) : -$signed({1'b0, sat_mag});
        end
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign day_difference = diff_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("start beat taken but sequencer did not leave idle");

    a_done_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_OUT))
        else $error("done strobe without a final step");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done strobe while still busy");

    a_sign: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (((day_difference[OUT_W-1] == 1'b0) && (day_difference != '0)) == before_reg))
        else $error("result sign disagrees with date order");

endmodule

### sv/dd_mac.sv
// Shared multiply-accumulate unit stepped by the sequencer.
module dd_mac #(
    parameter int ACC_W = 29
) (
    input  logic                          clk,
    input  dd_pkg::mac_ctl_t              ctl,
    input  logic signed [ACC_W-1:0]       a,
    input  logic [dd_pkg::MUL_B_W-1:0]    b,
    input  logic signed [ACC_W-1:0]       addend,
    output logic signed [ACC_W-1:0]       acc
);
    import dd_pkg::*;

    logic signed [ACC_W+MUL_B_W:0] prod_full;
    logic signed [ACC_W-1:0]       term;
    logic signed [ACC_W-1:0]       base;
    logic signed [ACC_W-1:0]       acc_reg;
    logic signed [ACC_W-1:0]       acc_next;

    assign prod_full = a * $signed({1'b0, b});
    assign term      = prod_full[ACC_W-1:0];
    assign base      = ctl.use_acc ? acc_reg : addend;
    assign acc_next  = ctl.sub ? (base - term) : (base + term);

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

### sv/dd_cal.sv
// Calendar corrections: century quotient fix-up, leap rule, clamping, day-of-year offset.
module dd_cal #(
    parameter int YEAR_BITS = 14,
    parameter int ACC_W     = 29
) (
    input  logic [YEAR_BITS-1:0]           year,
    input  logic [3:0]                     month_raw,
    input  logic [4:0]                     day_raw,
    input  logic signed [ACC_W-1:0]        rem,
    input  logic [YEAR_BITS-1:0]           q,
    output logic [YEAR_BITS-1:0]           c100,
    output logic [dd_pkg::OFF_W-1:0]       offset
);
    import dd_pkg::*;

    logic             rem_neg;
    logic [7:0]       rem_fix;
    logic             div100;
    logic             div400;
    logic             leap;
    logic [3:0]       month;
    logic [4:0]       mlen;
    logic [4:0]       day;
    logic [OFF_W-1:0] leap_add;

    always_comb
    begin
        rem_neg = rem[ACC_W-1];
        rem_fix = rem_neg ? (rem[7:0] + 8'd100) : rem[7:0];
        div100  = (rem_fix == 8'd99);
        c100    = rem_neg ? (q - YEAR_BITS'(1)) : q;
        div400  = div100 && (c100[1:0] == 2'd0);
        leap    = ((year[1:0] == 2'd0) && !div100) || div400;

        if (month_raw == 4'd0)
        begin
            month = 4'd1;
        end
        else if (month_raw > 4'd12)
        begin
            month = 4'd12;
        end
        else
        begin
            month = month_raw;
        end

        mlen = ((month == 4'd2) && leap) ? 5'd29 : month_len(month);

        if (day_raw == 5'd0)
        begin
            day = 5'd1;
        end
        else if (day_raw > mlen)
        begin
            day = mlen;
        end
        else
        begin
            day = day_raw;
        end

        leap_add = ((month > 4'd2) && leap) ? OFF_W'(1) : OFF_W'(0);
        offset   = days_before(month) + leap_add + OFF_W'(day) - OFF_W'(1);
    end

endmodule

### tb/tb_top.sv
// Self-checking testbench for date_difference_days: directed table, then random date pairs.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int YB = dd_pkg::YEAR_BITS_DEF;
    localparam int OW = dd_pkg::OUT_W;
    localparam int RANDOM_ITEMS = 1600;
    localparam int DIRECTED_ITEMS = 21;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [4:0]           first_day;
        logic [3:0]           first_month;
        logic [YB-1:0]        first_year;
        logic [4:0]           second_day;
        logic [3:0]           second_month;
        logic [YB-1:0]        second_year;
        logic                 count_end_day;
        logic                 has_exp;
        logic signed [OW-1:0] exp_diff;
    } date_pair_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [4:0]           first_day;
    logic [3:0]           first_month;
    logic [YB-1:0]        first_year;
    logic [4:0]           second_day;
    logic [3:0]           second_month;
    logic [YB-1:0]        second_year;
    logic                 count_end_day;
    logic                 done;
    logic signed [OW-1:0] day_difference;

    logic signed [OW-1:0] expected_diffs[$];
    int                   mismatches;
    int                   results_seen;
    bit                   quiet;

    // rows: first date, second date, end-day flag, typed expectation (if any)
    date_pair_t directed_rows [DIRECTED_ITEMS] = '{
        '{5'd1,  4'd1,  14'd2000,  5'd1,  4'd1,  14'd2000,  1'b0, 1'b1, 23'sd0},
        '{5'd1,  4'd1,  14'd2000,  5'd1,  4'd1,  14'd2000,  1'b1, 1'b1, -23'sd1},
        '{5'd1,  4'd1,  14'd2000,  5'd2,  4'd1,  14'd2000,  1'b0, 1'b1, 23'sd1},
        '{5'd2,  4'd1,  14'd2000,  5'd1,  4'd1,  14'd2000,  1'b0, 1'b1, -23'sd1},
        '{5'd2,  4'd1,  14'd2000,  5'd1,  4'd1,  14'd2000,  1'b1, 1'b1, -23'sd2},
        '{5'd1,  4'd1,  14'd0,     5'd1,  4'd1,  14'd16383, 1'b0, 1'b1, 23'sd4194303},
        '{5'd1,  4'd1,  14'd16383, 5'd1,  4'd1,  14'd0,     1'b1, 1'b1, -23'sd4194303},
        '{5'd0,  4'd0,  14'd0,     5'd1,  4'd1,  14'd0,     1'b0, 1'b1, 23'sd0},
        '{5'd31, 4'd15, 14'd2023,  5'd31, 4'd12, 14'd2023,  1'b0, 1'b1, 23'sd0},
        '{5'd30, 4'd2,  14'd2001,  5'd28, 4'd2,  14'd2001,  1'b0, 1'b1, 23'sd0},
        '{5'd31, 4'd2,  14'd2004,  5'd29, 4'd2,  14'd2004,  1'b1, 1'b1, -23'sd1},
        '{5'd28, 4'd2,  14'd1900,  5'd1,  4'd3,  14'd1900,  1'b0, 1'b1, 23'sd1},
        '{5'd31, 4'd4,  14'd2021,  5'd1,  4'd5,  14'd2021,  1'b0, 1'b1, 23'sd1},
        '{5'd28, 4'd2,  14'd2000,  5'd1,  4'd3,  14'd2000,  1'b0, 1'b0, 23'sd0},
        '{5'd1,  4'd1,  14'd1,     5'd31, 4'd12, 14'd9999,  1'b1, 1'b0, 23'sd0},
        '{5'd31, 4'd12, 14'd9999,  5'd1,  4'd1,  14'd1,     1'b0, 1'b0, 23'sd0},
        '{5'd31, 4'd13, 14'd0,     5'd0,  4'd0,  14'd1,     1'b0, 1'b0, 23'sd0},
        '{5'd1,  4'd3,  14'd1,     5'd1,  4'd3,  14'd10000, 1'b0, 1'b0, 23'sd0},
        '{5'd1,  4'd1,  14'd2100,  5'd1,  4'd1,  14'd2101,  1'b0, 1'b0, 23'sd0},
        '{5'd31, 4'd15, 14'd16383, 5'd0,  4'd0,  14'd16383, 1'b1, 1'b0, 23'sd0},
        '{5'd15, 4'd6,  14'd1999,  5'd14, 4'd6,  14'd1999,  1'b0, 1'b1, -23'sd1}
    };

    date_difference_days #(.YEAR_BITS(YB)) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .first_day      (first_day),
        .first_month    (first_month),
        .first_year     (first_year),
        .second_day     (second_day),
        .second_month   (second_month),
        .second_year    (second_year),
        .count_end_day  (count_end_day),
        .done           (done),
        .day_difference (day_difference)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic bit cal_leap(input int unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int unsigned cal_month_len(input int unsigned y, input int unsigned m);
        int unsigned len;
        case (m)
            4, 6, 9, 11: len = 30;
            2:           len = cal_leap(y) ? 29 : 28;
            default:     len = 31;
        endcase
        return len;
    endfunction

    // days since 1 January of year 0, after clamping month and day
    function automatic int unsigned day_serial(input int unsigned d, input int unsigned m,
                                               input int unsigned y);
        int unsigned n;
        if (m < 1)
            m = 1;
        if (m > 12)
            m = 12;
        if (d < 1)
            d = 1;
        if (d > cal_month_len(y, m))
            d = cal_month_len(y, m);
        n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
        for (int k = 1; k < m; k++)
            n += cal_month_len(y, k);
        return n + d - 1;
    endfunction

    function automatic logic signed [OW-1:0] days_between(input date_pair_t p);
        int unsigned          a;
        int unsigned          b;
        int unsigned          mag;
        bit                   earlier;
        logic signed [OW-1:0] v;
        a = day_serial(p.first_day, p.first_month, p.first_year);
        b = day_serial(p.second_day, p.second_month, p.second_year);
        earlier = a < b;
        mag = earlier ? b - a : a - b;
        mag += p.count_end_day;
        if (mag > dd_pkg::OUT_MAX_MAG)
            mag = dd_pkg::OUT_MAX_MAG;
        v = mag[OW-1:0];
        return earlier ? v : -v;
    endfunction

    function automatic date_pair_t random_pair();
        date_pair_t  p;
        int unsigned r;
        int          yy;
        p = '0;
        r = $urandom_range(99);
        if (r < 15)
        begin
            // raw field noise: out-of-range months, days and years
            p.first_day     = 5'($urandom);
            p.first_month   = 4'($urandom);
            p.first_year    = YB'($urandom);
            p.second_day    = 5'($urandom);
            p.second_month  = 4'($urandom);
            p.second_year   = YB'($urandom);
        end
        else
        begin
            p.first_year  = YB'($urandom_range(1, 9999));
            p.first_month = 4'($urandom_range(1, 12));
            p.first_day   = 5'($urandom_range(1, cal_month_len(p.first_year, p.first_month)));
            if (r < 25)
            begin
                p.second_day   = p.first_day;
                p.second_month = p.first_month;
                p.second_year  = p.first_year;
            end
            else
            begin
                if (r < 70)
                begin
                    yy = p.first_year;
                    yy = yy + int'($urandom_range(6)) - 3;
                    if (yy < 1)
                        yy = 1;
                    if (yy > 9999)
                        yy = 9999;
                    p.second_year = YB'(yy);
                end
                else
                    p.second_year = YB'($urandom_range(1, 9999));
                p.second_month = 4'($urandom_range(1, 12));
                p.second_day   = 5'($urandom_range(1, cal_month_len(p.second_year,
                                                                    p.second_month)));
            end
        end
        p.count_end_day = 1'($urandom);
        return p;
    endfunction

    task automatic send_beat(input date_pair_t p);
        int gap;
        if (!quiet && $urandom_range(99) < 9)
        begin
            gap = $urandom_range(1, 24);
            repeat (gap) @(negedge clk) start <= 1'b0;
        end
        @(negedge clk);
        first_day     <= p.first_day;
        first_month   <= p.first_month;
        first_year    <= p.first_year;
        second_day    <= p.second_day;
        second_month  <= p.second_month;
        second_year   <= p.second_year;
        count_end_day <= p.count_end_day;
        start         <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_diffs.push_back(p.has_exp ? p.exp_diff : days_between(p));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            results_seen++;
            if (expected_diffs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: unexpected beat, day_difference %0d",
                             results_seen, day_difference);
            end
            else if (day_difference !== expected_diffs[0])
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: day_difference expected %0d got %0d",
                             results_seen, expected_diffs[0], day_difference);
                void'(expected_diffs.pop_front());
            end
            else
                void'(expected_diffs.pop_front());
        end
    end

    initial
    begin
        mismatches    = 0;
        results_seen  = 0;
        quiet         = 1'b0;
        rst_n         = 1'b0;
        start         = 1'b0;
        first_day     = '0;
        first_month   = '0;
        first_year    = '0;
        second_day    = '0;
        second_month  = '0;
        second_year   = '0;
        count_end_day = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ITEMS; i++)
            send_beat(directed_rows[i]);
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            quiet = (i >= 500) && (i < 900);
            send_beat(random_pair());
        end
        @(negedge clk) start <= 1'b0;

        while (expected_diffs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_diffs.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule

### filelist.f
sv/dd_pkg.sv
sv/dd_mac.sv
sv/dd_cal.sv
sv/date_difference_days.sv
tb/tb_top.sv
